// ===== rtl/ansicur_pkg.sv =====
// Shared types, character codes and color palette for the ANSI text console core.
// No dependencies; used by every module of the block.
package ansicur_pkg;

  localparam int ArgSlotsDef   = 8;
  localparam int QueueDepthDef = 4;

  localparam int ACC_W   = 10;
  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACC_W-1:0] ACC_MAX     = 10'd1023;
  localparam logic [ACC_W-1:0] CMD_FG      = 10'd38;
  localparam logic [ACC_W-1:0] CMD_BG      = 10'd48;
  localparam logic [ACC_W-1:0] ARG_PALETTE = 10'd5;
  localparam logic [ACC_W-1:0] ARG_DIRECT  = 10'd2;

  localparam logic [7:0] CHR_NUL  = 8'h00;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_ESC  = 8'h1B;
  localparam logic [7:0] CHR_SEMI = 8'h3B;
  localparam logic [7:0] CHR_LBR  = 8'h5B;
  localparam logic [7:0] CHR_M    = 8'h6D;
  localparam logic [7:0] CHR_0    = 8'h30;
  localparam logic [7:0] CHR_9    = 8'h39;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

  localparam logic [7:0] NUM_COLS_RST = 8'd80;
  localparam logic [7:0] NUM_ROWS_RST = 8'd25;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_DRAW    = 2'd1,
    ACT_NEWLINE = 2'd2,
    ACT_CR      = 2'd3
  } act_e;

  typedef enum logic {
    EV_DRAW   = 1'b0,
    EV_SCROLL = 1'b1
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLS = 1'b0,
    REG_NUM_ROWS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic               esc_first;
    act_e               act;
    logic [7:0]         glyph;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } op_t;

  localparam int OP_W = $bits(op_t);

  typedef struct packed {
    event_e             kind;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [7:0]         glyph;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [COLOR_W-1:0] palette(input logic [3:0] idx);
    logic [COLOR_W-1:0] col;
    unique case (idx)
      4'd0:  col = 24'h000000;
      4'd1:  col = 24'hAA0000;
      4'd2:  col = 24'h00AA00;
      4'd3:  col = 24'hAAAA00;
      4'd4:  col = 24'h0000AA;
      4'd5:  col = 24'hAA00AA;
      4'd6:  col = 24'h00AAAA;
      4'd7:  col = 24'hAAAAAA;
      4'd8:  col = 24'h555555;
      4'd9:  col = 24'hFF5555;
      4'd10: col = 24'h55FF55;
      4'd11: col = 24'hFFFF55;
      4'd12: col = 24'h5555FF;
      4'd13: col = 24'hFF55FF;
      4'd14: col = 24'h55FFFF;
      default: col = 24'hFFFFFF;
    endcase
    return col;
  endfunction

endpackage

// ===== rtl/text_console_ansi_cursor_core.sv =====
// Top level of the ANSI text console core: geometry registers, parser front end,
// operation queue and cursor back end. Uses ansicur_pkg, ansicur_front/fifo/back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   input    | in_valid_i / in_stall_o   | char_byte_i, write_start_i
//   result   | out_valid_o / out_stall_i | event_kind_o .. bg_blue_o, last_result_o
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A byte is taken every cycle while the operation queue has room. The output
// drain sets the rate: a byte with k results (k up to 4) holds the back end
// until all k are drained; bytes without results cost one queue slot or none.
// Reset clears cursor, colors, parser and geometry (80 x 25). An output stall
// backs up through the queue into in_stall_o.
module text_console_ansi_cursor_core #(
  parameter int ARG_SLOTS   = ansicur_pkg::ArgSlotsDef,
  parameter int QUEUE_DEPTH = ansicur_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        char_byte_i,
  input  logic                              write_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              event_kind_o,
  output logic [7:0]                        cell_col_o,
  output logic [7:0]                        cell_row_o,
  output logic [7:0]                        glyph_code_o,
  output logic [7:0]                        fg_red_o,
  output logic [7:0]                        fg_green_o,
  output logic [7:0]                        fg_blue_o,
  output logic [7:0]                        bg_red_o,
  output logic [7:0]                        bg_green_o,
  output logic [7:0]                        bg_blue_o,
  output logic                              last_result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ansicur_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);

  logic [7:0]                 num_cols_q, num_rows_q;
  logic [7:0]                 cols_eff, rows_eff;
  logic                       accept;
  logic                       push;
  ansicur_pkg::op_t           op_in, op_out;
  logic [ansicur_pkg::OP_W-1:0] op_raw;
  ansicur_pkg::queue_status_t q_status;
  logic                       pop;
  ansicur_pkg::result_t       res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= ansicur_pkg::NUM_COLS_RST;
      num_rows_q <= ansicur_pkg::NUM_ROWS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ansicur_pkg::reg_idx_e'(cfg_index_i))
        ansicur_pkg::REG_NUM_COLS: num_cols_q <= cfg_data_i;
        ansicur_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data_i;
        default: num_cols_q <= num_cols_q;
      endcase
    end
  end

  assign cols_eff = (num_cols_q == 8'd0) ? 8'd1 : num_cols_q;
  assign rows_eff = (num_rows_q == 8'd0) ? 8'd1 : num_rows_q;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  ansicur_front #(
    .ARG_SLOTS (ARG_SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_byte_i   (char_byte_i),
    .write_start_i (write_start_i),
    .push_o        (push),
    .op_o          (op_in)
  );

  ansicur_fifo #(
    .WIDTH (ansicur_pkg::OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (op_in),
    .pop_i    (pop),
    .data_o   (op_raw),
    .status_o (q_status)
  );

  assign op_out = ansicur_pkg::op_t'(op_raw);

  ansicur_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cols_i      (cols_eff),
    .rows_i      (rows_eff),
    .op_valid_i  (!q_status.empty),
    .op_i        (op_out),
    .op_pop_o    (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (res)
  );

  assign event_kind_o  = res.kind;
  assign cell_col_o    = res.col;
  assign cell_row_o    = res.row;
  assign glyph_code_o  = res.glyph;
  assign fg_red_o      = res.fg[23:16];
  assign fg_green_o    = res.fg[15:8];
  assign fg_blue_o     = res.fg[7:0];
  assign bg_red_o      = res.bg[23:16];
  assign bg_green_o    = res.bg[15:8];
  assign bg_blue_o     = res.bg[7:0];
  assign last_result_o = res.last;

endmodule

// ===== rtl/ansicur_front.sv =====
// Front end: accepts console bytes, runs the escape/SGR parser and holds the colors.
// Emits one cursor operation per byte that touches the screen. Uses ansicur_pkg.
module ansicur_front #(
  parameter int ARG_SLOTS = ansicur_pkg::ArgSlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_byte_i,
  input  logic                write_start_i,
  output logic                push_o,
  output ansicur_pkg::op_t    op_o
);

  localparam int FI_W   = $clog2(ARG_SLOTS + 2);
  localparam int SLOT_W = $clog2(ARG_SLOTS);
  localparam int ACC_W  = ansicur_pkg::ACC_W;
  localparam int COLOR_W = ansicur_pkg::COLOR_W;

  logic                in_seq_q, in_seq_d;
  logic                esc_q, esc_d;
  logic                stop_q, stop_d;
  logic [FI_W-1:0]     fi_q, fi_d;
  logic [ACC_W-1:0]    cmd_q, cmd_d;
  logic [ACC_W-1:0]    args_q [ARG_SLOTS];
  logic [ACC_W-1:0]    args_d [ARG_SLOTS];
  logic [COLOR_W-1:0]  fg_q, fg_d;
  logic [COLOR_W-1:0]  bg_q, bg_d;

  logic                esc_first;
  logic                go;
  ansicur_pkg::act_e   act;
  logic [SLOT_W-1:0]   slot;
  logic [ACC_W-1:0]    acc_cur;
  logic [13:0]         acc_prod;
  logic [ACC_W-1:0]    acc_new;
  logic [COLOR_W-1:0]  pick;

  always_comb begin
    in_seq_d  = in_seq_q;
    esc_d     = esc_q;
    stop_d    = stop_q;
    fi_d      = fi_q;
    cmd_d     = cmd_q;
    args_d    = args_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    esc_first = 1'b0;
    go        = 1'b0;
    act       = ansicur_pkg::ACT_NONE;
    push_o    = 1'b0;
    slot      = SLOT_W'(fi_q - FI_W'(1));
    acc_cur   = (fi_q == '0) ? cmd_q : args_q[slot];
    acc_prod  = {4'd0, acc_cur} * 14'd10 + {10'd0, char_byte_i[3:0]};
    acc_new   = (acc_prod > {4'd0, ansicur_pkg::ACC_MAX}) ? ansicur_pkg::ACC_MAX
                                                          : acc_prod[ACC_W-1:0];
    if (args_q[0] == ansicur_pkg::ARG_PALETTE) begin
      pick = ansicur_pkg::palette(args_q[1][3:0]);
    end else begin
      pick = {args_q[1][7:0], args_q[2][7:0], args_q[3][7:0]};
    end

    if (accept_i) begin
      if (write_start_i) begin
        in_seq_d = 1'b0;
        esc_d    = 1'b0;
        stop_d   = 1'b0;
        fi_d     = '0;
        cmd_d    = '0;
        for (int i = 0; i < ARG_SLOTS; i++) args_d[i] = '0;
      end
      if (!stop_d) begin
        if (in_seq_d) begin
          priority if (char_byte_i == ansicur_pkg::CHR_SEMI) begin
            if (fi_q <= FI_W'(ARG_SLOTS)) fi_d = fi_q + FI_W'(1);
          end else if (char_byte_i == ansicur_pkg::CHR_M) begin
            if (args_q[0] == ansicur_pkg::ARG_PALETTE || args_q[0] == ansicur_pkg::ARG_DIRECT) begin
              if (cmd_q == ansicur_pkg::CMD_FG) begin
                fg_d = pick;
              end else if (cmd_q == ansicur_pkg::CMD_BG) begin
                bg_d = pick;
              end
            end
            in_seq_d = 1'b0;
          end else if (char_byte_i >= ansicur_pkg::CHR_0 && char_byte_i <= ansicur_pkg::CHR_9) begin
            if (fi_q == '0) begin
              cmd_d = acc_new;
            end else if (fi_q <= FI_W'(ARG_SLOTS)) begin
              args_d[slot] = acc_new;
            end
          end else begin
            in_seq_d = in_seq_q;
          end
        end else begin
          go = 1'b1;
          if (esc_d) begin
            esc_d = 1'b0;
            if (char_byte_i == ansicur_pkg::CHR_LBR) begin
              fi_d     = '0;
              cmd_d    = '0;
              for (int i = 0; i < ARG_SLOTS; i++) args_d[i] = '0;
              in_seq_d = 1'b1;
              go       = 1'b0;
            end else begin
              esc_first = 1'b1;
            end
          end
          if (go) begin
            unique case (char_byte_i)
              ansicur_pkg::CHR_LF:  act = ansicur_pkg::ACT_NEWLINE;
              ansicur_pkg::CHR_CR:  act = ansicur_pkg::ACT_CR;
              ansicur_pkg::CHR_ESC: esc_d = 1'b1;
              ansicur_pkg::CHR_NUL: stop_d = 1'b1;
              default:              act = ansicur_pkg::ACT_DRAW;
            endcase
          end
          push_o = esc_first || (act != ansicur_pkg::ACT_NONE);
        end
      end
    end
  end

  assign op_o.esc_first = esc_first;
  assign op_o.act       = act;
  assign op_o.glyph     = char_byte_i;
  assign op_o.fg        = fg_q;
  assign op_o.bg        = bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seq_q <= 1'b0;
      esc_q    <= 1'b0;
      stop_q   <= 1'b0;
      fi_q     <= '0;
      cmd_q    <= '0;
      for (int i = 0; i < ARG_SLOTS; i++) args_q[i] <= '0;
      fg_q     <= ansicur_pkg::COLOR_WHITE;
      bg_q     <= ansicur_pkg::COLOR_BLACK;
    end else begin
      in_seq_q <= in_seq_d;
      esc_q    <= esc_d;
      stop_q   <= stop_d;
      fi_q     <= fi_d;
      cmd_q    <= cmd_d;
      args_q   <= args_d;
      fg_q     <= fg_d;
      bg_q     <= bg_d;
    end
  end

endmodule

// ===== rtl/ansicur_fifo.sv =====
// Short register queue between the parser front end and the cursor back end.
// Generic width and depth; status travels as ansicur_pkg::queue_status_t.
module ansicur_fifo #(
  parameter int WIDTH = ansicur_pkg::OP_W,
  parameter int DEPTH = ansicur_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output ansicur_pkg::queue_status_t status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/ansicur_back.sv =====
// Back end: moves the cursor for each queued operation, plans its draw and scroll
// events, and drains them one per unstalled cycle into out_q. Uses ansicur_pkg.
module ansicur_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           cols_i,
  input  logic [7:0]           rows_i,
  input  logic                 op_valid_i,
  input  ansicur_pkg::op_t     op_i,
  output logic                 op_pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output ansicur_pkg::result_t out_o
);

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       scroll;
  } cur_t;

  typedef struct packed {
    logic [3:0]                         mask;
    logic [7:0]                         esc_col;
    logic [7:0]                         esc_row;
    logic [7:0]                         main_col;
    logic [7:0]                         main_row;
    logic [7:0]                         glyph;
    logic [ansicur_pkg::COLOR_W-1:0]    fg;
    logic [ansicur_pkg::COLOR_W-1:0]    bg;
  } plan_t;

  function automatic cur_t advance(input logic [7:0] c, input logic [7:0] r,
                                   input logic [7:0] cols, input logic [7:0] rows,
                                   input logic nl);
    cur_t       res;
    logic [8:0] cn;
    logic [8:0] rn;
    cn = {1'b0, c} + 9'd1;
    rn = {1'b0, r} + 9'd1;
    res.col    = c;
    res.row    = r;
    res.scroll = 1'b0;
    if (nl || cn >= {1'b0, cols}) begin
      res.col = 8'd0;
      if (rn >= {1'b0, rows}) begin
        res.scroll = 1'b1;
        res.row    = rows - 8'd1;
      end else begin
        res.row = rn[7:0];
      end
    end else begin
      res.col = cn[7:0];
    end
    return res;
  endfunction

  logic [7:0]           col_q, col_d;
  logic [7:0]           row_q, row_d;
  plan_t                plan_q, plan_d;
  logic                 out_valid_q;
  ansicur_pkg::result_t out_q, res;
  cur_t                 u_esc, u_main;
  logic [7:0]           c1, r1;
  logic                 m_draw, m_scroll;
  logic [3:0]           sel, mask_after;
  logic                 out_load, take;

  assign out_load   = (plan_q.mask != '0) && (!out_valid_q || !out_stall_i);
  assign sel        = plan_q.mask & (~plan_q.mask + 4'd1);
  assign mask_after = out_load ? (plan_q.mask & ~sel) : plan_q.mask;
  assign take       = op_valid_i && (mask_after == '0);
  assign op_pop_o   = take;

  always_comb begin
    u_esc = advance(col_q, row_q, cols_i, rows_i, 1'b0);
    c1    = op_i.esc_first ? u_esc.col : col_q;
    r1    = op_i.esc_first ? u_esc.row : row_q;
    u_main = advance(c1, r1, cols_i, rows_i, op_i.act == ansicur_pkg::ACT_NEWLINE);
    col_d    = c1;
    row_d    = r1;
    m_draw   = 1'b0;
    m_scroll = 1'b0;
    unique case (op_i.act)
      ansicur_pkg::ACT_NONE: begin
      end
      ansicur_pkg::ACT_DRAW: begin
        col_d    = u_main.col;
        row_d    = u_main.row;
        m_draw   = 1'b1;
        m_scroll = u_main.scroll;
      end
      ansicur_pkg::ACT_NEWLINE: begin
        col_d    = u_main.col;
        row_d    = u_main.row;
        m_scroll = u_main.scroll;
      end
      ansicur_pkg::ACT_CR: begin
        col_d = 8'd0;
      end
      default: begin
      end
    endcase

    plan_d = plan_q;
    plan_d.mask = mask_after;
    if (take) begin
      plan_d.mask     = {m_scroll, m_draw, op_i.esc_first & u_esc.scroll, op_i.esc_first};
      plan_d.esc_col  = col_q;
      plan_d.esc_row  = row_q;
      plan_d.main_col = c1;
      plan_d.main_row = r1;
      plan_d.glyph    = op_i.glyph;
      plan_d.fg       = op_i.fg;
      plan_d.bg       = op_i.bg;
    end

    res.fg    = plan_q.fg;
    res.bg    = plan_q.bg;
    res.last  = ((plan_q.mask & ~sel) == '0);
    priority if (sel[0]) begin
      res.kind  = ansicur_pkg::EV_DRAW;
      res.col   = plan_q.esc_col;
      res.row   = plan_q.esc_row;
      res.glyph = ansicur_pkg::CHR_ESC;
    end else if (sel[2]) begin
      res.kind  = ansicur_pkg::EV_DRAW;
      res.col   = plan_q.main_col;
      res.row   = plan_q.main_row;
      res.glyph = plan_q.glyph;
    end else begin
      res.kind  = ansicur_pkg::EV_SCROLL;
      res.col   = 8'd0;
      res.row   = 8'd0;
      res.glyph = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= 8'd0;
      row_q       <= 8'd0;
      plan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      plan_q <= plan_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/ansicur_checker.sv =====
// Port-level checks for text_console_ansi_cursor_core, attached by bind.
// Uses ansicur_pkg for event and character codes.
module ansicur_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       event_kind_o,
  input logic [7:0] cell_col_o,
  input logic [7:0] cell_row_o,
  input logic [7:0] glyph_code_o,
  input logic [7:0] fg_red_o,
  input logic [7:0] fg_green_o,
  input logic [7:0] fg_blue_o,
  input logic [7:0] bg_red_o,
  input logic [7:0] bg_green_o,
  input logic [7:0] bg_blue_o,
  input logic       last_result_o
);

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> out_valid_o)
    else $error("result burst broken before its last item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(cell_col_o) && $stable(cell_row_o) && $stable(glyph_code_o) &&
      $stable(fg_red_o) && $stable(fg_green_o) && $stable(fg_blue_o) &&
      $stable(bg_red_o) && $stable(bg_green_o) && $stable(bg_blue_o) &&
      $stable(last_result_o))
    else $error("stalled result changed");

  a_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == ansicur_pkg::EV_SCROLL |->
      cell_col_o == 8'd0 && cell_row_o == 8'd0 && glyph_code_o == 8'd0)
    else $error("scroll item carries cell data");

  a_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == ansicur_pkg::EV_DRAW |->
      glyph_code_o != ansicur_pkg::CHR_NUL && glyph_code_o != ansicur_pkg::CHR_LF &&
      glyph_code_o != ansicur_pkg::CHR_CR)
    else $error("control byte drawn as glyph");

endmodule

bind text_console_ansi_cursor_core ansicur_checker u_ansicur_checker (.*);

// ===== tb/sv/text_console_ansi_cursor_core_test.sv =====
// Self-checking testbench for text_console_ansi_cursor_core: directed table, then random
// text, SGR color sequences and stop/restart runs over several screen geometries.
// Depends on ansicur_pkg and the core RTL; predicts events with its own console model.
module text_console_ansi_cursor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ansicur_pkg::*;

  localparam int NUM_ARGS        = ArgSlotsDef;
  localparam int NUM_DIRECTED    = 30;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 8;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 200;
  localparam int TYPED_NONE      = 0;
  localparam int TYPED_ONE       = 1;
  localparam int PREDICTED       = -1;

  localparam logic [COLOR_W-1:0] VGA_PALETTE [16] = '{
    24'h000000, 24'hAA0000, 24'h00AA00, 24'hAAAA00,
    24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA,
    24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
    24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
  };

  localparam logic [7:0] GEO_COLS [NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd6, 8'd2, 8'd255};
  localparam logic [7:0] GEO_ROWS [NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd255, 8'd1};

  typedef struct {
    logic [7:0]         chr;
    logic               start;
    int                 typed_n;
    event_e             kind;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [7:0]         glyph;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } step_row_t;

  step_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h41, 1'b1, TYPED_ONE, EV_DRAW, 8'd0, 8'd0, 8'h41, COLOR_WHITE, COLOR_BLACK},
    '{8'hFF, 1'b0, TYPED_ONE, EV_DRAW, 8'd1, 8'd0, 8'hFF, COLOR_WHITE, COLOR_BLACK},
    '{CHR_CR,   1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_LF,   1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_ESC,  1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h5A,    1'b0, PREDICTED,  EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_ESC,  1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_LBR,  1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h33,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h38,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_SEMI, 1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h35,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_SEMI, 1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h32,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h35,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_M,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h71,    1'b0, PREDICTED,  EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_ESC,  1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_LBR,  1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h34,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h38,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_SEMI, 1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h32,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_SEMI, 1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h37,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_M,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h6B,    1'b0, PREDICTED,  EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{CHR_NUL,  1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h42,    1'b0, TYPED_NONE, EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0},
    '{8'h43,    1'b1, PREDICTED,  EV_DRAW, 8'd0, 8'd0, 8'd0, 24'd0, 24'd0}
  };

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [7:0]           char_byte   = 8'd0;
  logic                 write_start = 1'b0;
  logic                 out_stall   = 1'b1;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_NUM_COLS;
  logic [7:0]           cfg_data    = 8'd0;

  logic       in_stall_o, out_valid_o, cfg_ready_o;
  logic       event_kind_o, last_result_o;
  logic [7:0] cell_col_o, cell_row_o, glyph_code_o;
  logic [7:0] fg_red_o, fg_green_o, fg_blue_o, bg_red_o, bg_green_o, bg_blue_o;

  logic [7:0]         ncols_q, nrows_q, col_q, row_q;
  logic [COLOR_W-1:0] fore_q, back_q;
  logic               in_seq_q, esc_q, stopped_q;
  logic [3:0]         field_q;
  logic [ACC_W-1:0]   cmd_q;
  logic [ACC_W-1:0]   args_q [NUM_ARGS];

  result_t     step_events [$];
  result_t     events_due [$];
  int unsigned errors      = 0;
  int unsigned events_seen = 0;
  int unsigned sent_items  = 0;
  int unsigned live_items  = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_hold   = 0;
  bit          quiet       = 1'b0;

  text_console_ansi_cursor_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .char_byte_i   (char_byte),
    .write_start_i (write_start),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .event_kind_o  (event_kind_o),
    .cell_col_o    (cell_col_o),
    .cell_row_o    (cell_row_o),
    .glyph_code_o  (glyph_code_o),
    .fg_red_o      (fg_red_o),
    .fg_green_o    (fg_green_o),
    .fg_blue_o     (fg_blue_o),
    .bg_red_o      (bg_red_o),
    .bg_green_o    (bg_green_o),
    .bg_blue_o     (bg_blue_o),
    .last_result_o (last_result_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_ansi_cursor_core: mismatch");
      $finish;
    end
  end

  function automatic void clear_parser();
    in_seq_q = 1'b0;
    esc_q    = 1'b0;
    field_q  = '0;
    cmd_q    = '0;
    foreach (args_q[i]) args_q[i] = '0;
  endfunction

  function automatic void reset_console();
    ncols_q   = NUM_COLS_RST;
    nrows_q   = NUM_ROWS_RST;
    col_q     = '0;
    row_q     = '0;
    fore_q    = COLOR_WHITE;
    back_q    = COLOR_BLACK;
    stopped_q = 1'b0;
    clear_parser();
  endfunction

  function automatic void push_event(event_e kind, logic [7:0] col, logic [7:0] row,
                                     logic [7:0] glyph);
    result_t ev;
    if (step_events.size() >= 4) return;
    ev.kind  = kind;
    ev.col   = col;
    ev.row   = row;
    ev.glyph = glyph;
    ev.fg    = fore_q;
    ev.bg    = back_q;
    ev.last  = 1'b0;
    step_events.push_back(ev);
  endfunction

  function automatic void next_row();
    logic [7:0] rows;
    rows  = (nrows_q == 8'd0) ? 8'd1 : nrows_q;
    col_q = '0;
    if (int'(row_q) + 1 >= int'(rows)) begin
      push_event(EV_SCROLL, 8'd0, 8'd0, 8'd0);
      row_q = rows - 8'd1;
    end else begin
      row_q = row_q + 8'd1;
    end
  endfunction

  function automatic void draw_cell(logic [7:0] glyph);
    logic [7:0] cols;
    cols = (ncols_q == 8'd0) ? 8'd1 : ncols_q;
    push_event(EV_DRAW, col_q, row_q, glyph);
    if (int'(col_q) + 1 >= int'(cols)) next_row();
    else col_q = col_q + 8'd1;
  endfunction

  function automatic logic [COLOR_W-1:0] chosen_color();
    if (args_q[0] == ARG_PALETTE) return VGA_PALETTE[args_q[1][3:0]];
    return {args_q[1][7:0], args_q[2][7:0], args_q[3][7:0]};
  endfunction

  function automatic void apply_sgr();
    if (args_q[0] == ARG_PALETTE || args_q[0] == ARG_DIRECT) begin
      if (cmd_q == CMD_FG) fore_q = chosen_color();
      else if (cmd_q == CMD_BG) back_q = chosen_color();
    end
  endfunction

  function automatic void sgr_byte(logic [7:0] c);
    int acc;
    if (c == CHR_SEMI) begin
      if (field_q <= NUM_ARGS) field_q = field_q + 4'd1;
    end else if (c == CHR_M) begin
      apply_sgr();
      in_seq_q = 1'b0;
    end else if (c >= CHR_0 && c <= CHR_9 && field_q <= NUM_ARGS) begin
      acc = (field_q == 4'd0) ? int'(cmd_q) : int'(args_q[field_q - 1]);
      acc = acc * 10 + int'(c - CHR_0);
      if (acc > int'(ACC_MAX)) acc = int'(ACC_MAX);
      if (field_q == 4'd0) cmd_q = acc[ACC_W-1:0];
      else args_q[field_q - 1] = acc[ACC_W-1:0];
    end
  endfunction

  function automatic void text_byte(logic [7:0] c);
    if (esc_q) begin
      esc_q = 1'b0;
      if (c == CHR_LBR) begin
        clear_parser();
        in_seq_q = 1'b1;
        return;
      end
      draw_cell(CHR_ESC);
    end
    if (c == CHR_LF) next_row();
    else if (c == CHR_CR) col_q = '0;
    else if (c == CHR_ESC) esc_q = 1'b1;
    else if (c == CHR_NUL) stopped_q = 1'b1;
    else draw_cell(c);
  endfunction

  // returns 0 when the byte is swallowed by a stopped write
  function automatic bit console_step(logic [7:0] c, logic start);
    result_t ev;
    step_events.delete();
    if (start) begin
      clear_parser();
      stopped_q = 1'b0;
    end
    if (stopped_q) return 1'b0;
    if (in_seq_q) sgr_byte(c);
    else text_byte(c);
    if (step_events.size() != 0) begin
      ev = step_events.pop_back();
      ev.last = 1'b1;
      step_events.push_back(ev);
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (events_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("event_kind: expected no event, got %0d at col %0d row %0d glyph %0d",
                 event_kind_o, cell_col_o, cell_row_o, glyph_code_o);
      end else begin
        want = events_due.pop_front();
        events_seen++;
        check_field("event_kind", want.kind, event_kind_o);
        check_field("cell_col", want.col, cell_col_o);
        check_field("cell_row", want.row, cell_row_o);
        check_field("glyph_code", want.glyph, glyph_code_o);
        check_field("fg_red", want.fg[23:16], fg_red_o);
        check_field("fg_green", want.fg[15:8], fg_green_o);
        check_field("fg_blue", want.fg[7:0], fg_blue_o);
        check_field("bg_red", want.bg[23:16], bg_red_o);
        check_field("bg_green", want.bg[15:8], bg_green_o);
        check_field("bg_blue", want.bg[7:0], bg_blue_o);
        check_field("last_result", want.last, last_result_o);
      end
    end
  end

  initial begin : result_sink
    int unsigned pause;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold != 0) begin
        out_stall <= 1'b1;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      pause = quiet ? 0 : $urandom_range(0, 3);
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic s, input int typed_n = PREDICTED,
                          input result_t typed_ev = '0);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    char_byte   <= b;
    write_start <= s;
    do @(posedge clk); while (in_stall_o);
    sent_items++;
    if (console_step(b, s)) live_items++;
    if (typed_n == PREDICTED) begin
      foreach (step_events[i]) events_due.push_back(step_events[i]);
    end else if (typed_n == TYPED_ONE) begin
      events_due.push_back(typed_ev);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_geometry(input logic [7:0] cols, input logic [7:0] rows);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NUM_COLS;
    cfg_data  <= cols;
    do @(posedge clk); while (!cfg_ready_o);
    ncols_q = cols;
    cfg_index <= REG_NUM_ROWS;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready_o);
    nrows_q = rows;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return CHR_NUL;
      1:       return CHR_LF;
      2:       return CHR_CR;
      3:       return CHR_ESC;
      4:       return 8'h78;
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  task automatic send_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) begin
      if ($urandom_range(0, 19) == 0) put_byte(noise_byte(), 1'b0);
      put_byte(digits[i], 1'b0);
    end
  endtask

  task automatic send_text();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(1, 6);
    repeat (n) begin
      b = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(8'h20, 8'h7E))
                                       : 8'($urandom_range(0, 255));
      put_byte(b, $urandom_range(0, 49) == 0);
    end
  endtask

  task automatic send_sgr(input bit broken);
    int unsigned pick, mode, nargs, v;
    put_byte(CHR_ESC, 1'b0);
    put_byte(CHR_LBR, 1'b0);
    pick = $urandom_range(0, 9);
    v = (pick < 4) ? int'(CMD_FG) : (pick < 8) ? int'(CMD_BG)
      : (pick == 8) ? $urandom_range(0, 99) : $urandom_range(1000, 99999);
    if ($urandom_range(0, 19) != 0) send_number(v);
    put_byte(CHR_SEMI, 1'b0);
    pick = $urandom_range(0, 9);
    mode = (pick < 4) ? int'(ARG_PALETTE) : (pick < 8) ? int'(ARG_DIRECT)
         : $urandom_range(0, 20);
    send_number(mode);
    nargs = (mode == int'(ARG_PALETTE)) ? 1 : 3;
    if ($urandom_range(0, 5) == 0) nargs = $urandom_range(0, 12);
    repeat (nargs) begin
      put_byte(CHR_SEMI, 1'b0);
      v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999)
        : (mode == int'(ARG_PALETTE)) ? $urandom_range(0, 40) : $urandom_range(0, 255);
      if ($urandom_range(0, 9) != 0) send_number(v);
    end
    if (broken) put_byte(8'($urandom_range(0, 255)), 1'b1);
    else put_byte(CHR_M, 1'b0);
  endtask

  task automatic send_stop();
    put_byte(CHR_NUL, 1'b0);
    repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    put_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
  endtask

  task automatic random_burst();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_text();
    end else if (pick < 50) begin
      put_byte(($urandom_range(0, 1) != 0) ? CHR_LF : CHR_CR, 1'b0);
    end else if (pick < 80) begin
      send_sgr(1'b0);
    end else if (pick < 87) begin
      put_byte(CHR_ESC, 1'b0);
      put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end else if (pick < 93) begin
      send_stop();
    end else begin
      send_sgr(1'b1);
    end
  endtask

  initial begin : stimulus
    result_t     typed_ev;
    int unsigned phase_base;
    reset_console();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_ev.kind  = directed_rows[i].kind;
      typed_ev.col   = directed_rows[i].col;
      typed_ev.row   = directed_rows[i].row;
      typed_ev.glyph = directed_rows[i].glyph;
      typed_ev.fg    = directed_rows[i].fg;
      typed_ev.bg    = directed_rows[i].bg;
      typed_ev.last  = 1'b1;
      put_byte(directed_rows[i].chr, directed_rows[i].start, directed_rows[i].typed_n,
               typed_ev);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_geometry(GEO_COLS[p], GEO_ROWS[p]);
      quiet = (p == 4);
      if (p == 3) sink_hold = 60;
      phase_base = live_items;
      while (live_items - phase_base < ITEMS_PER_PHASE) begin
        random_burst();
        if ($urandom_range(0, 24) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d bytes (%0d directed, %0d not swallowed by a stopped write)",
             sent_items, NUM_DIRECTED, live_items);
    $display("%0d geometry settings after reset, %0d draw/scroll events compared",
             NUM_PHASES, events_seen);
    if (errors == 0 && events_due.size() == 0) begin
      $display("text_console_ansi_cursor_core: match");
    end else begin
      $display("text_console_ansi_cursor_core: mismatch");
    end
    $finish;
  end

endmodule
